>>> hdl/npc_pkg.sv
// Shared types, constants and a helper function for the nearest palette color search.
package npc_pkg;

   localparam int DEFAULT_DEPTH = 256;
   localparam int ENTRY_W = 8;
   localparam int COLOR_W = 8;
   localparam int SQ_W = 2 * COLOR_W;
   localparam int DIST_W = 18;
   localparam int MAX_DISTANCE = 195075;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } npc_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } npc_state_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } npc_color_type;

   // Control that travels with the entry leaving the head of the palette ring.
   typedef struct packed {
      logic               seed;
      logic               valid;
      logic [ENTRY_W-1:0] index;
   } npc_tap_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> hdl/npc_channels_if.sv
// Valid/ready channel interfaces for palette requests and search responses.
interface npc_req_if import npc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               op;
   logic [ENTRY_W-1:0] entry;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, op, entry, red, green, blue, input ready);
   modport sink (input valid, op, entry, red, green, blue, output ready);
endinterface

interface npc_rsp_if import npc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ENTRY_W-1:0] nearest_index;
   logic [DIST_W-1:0]  best_distance;

   modport source (output valid, nearest_index, best_distance, input ready);
   modport sink (input valid, nearest_index, best_distance, output ready);
endinterface

>>> hdl/npc_cell.sv
// One palette cell: holds an RGB entry and passes it to its neighbor while the ring rotates.
module npc_cell import npc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift,
   input  logic          load,
   input  npc_color_type load_data,
   input  npc_color_type next_data,
   output npc_color_type data
);

   npc_color_type data_ff;
   npc_color_type data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_data;
      end else if (shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

>>> hdl/npc_dist.sv
// Distance unit: squares the channel differences, then keeps the running minimum.
module npc_dist import npc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  npc_tap_type        tap,
   input  npc_color_type      query,
   input  npc_color_type      entry,
   output logic [ENTRY_W-1:0] nearest_index,
   output logic [DIST_W-1:0]  best_distance
);

   logic [COLOR_W-1:0] diff_r;
   logic [COLOR_W-1:0] diff_g;
   logic [COLOR_W-1:0] diff_b;

   logic [SQ_W-1:0]    sq_r_ff, sq_r_in;
   logic [SQ_W-1:0]    sq_g_ff, sq_g_in;
   logic [SQ_W-1:0]    sq_b_ff, sq_b_in;
   logic               s1_valid_ff;
   logic [ENTRY_W-1:0] s1_index_ff;

   logic [DIST_W-1:0]  sum;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [ENTRY_W-1:0] best_idx_ff, best_idx_in;

   always_comb begin
      diff_r  = abs_diff(query.red, entry.red);
      diff_g  = abs_diff(query.green, entry.green);
      diff_b  = abs_diff(query.blue, entry.blue);
      sq_r_in = SQ_W'(diff_r) * SQ_W'(diff_r);
      sq_g_in = SQ_W'(diff_g) * SQ_W'(diff_g);
      sq_b_in = SQ_W'(diff_b) * SQ_W'(diff_b);
   end

   always_ff @(posedge clock) begin
      sq_r_ff     <= sq_r_in;
      sq_g_ff     <= sq_g_in;
      sq_b_ff     <= sq_b_in;
      s1_index_ff <= tap.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= tap.valid;
      end
   end

   // The seed is above every reachable distance, so the first entry always wins and
   // the strict compare keeps the lowest index on a tie.
   always_comb begin
      sum          = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (tap.seed) begin
         best_dist_in = '1;
         best_idx_in  = ENTRY_W'(1);
      end else if (s1_valid_ff && (sum < best_dist_ff)) begin
         best_dist_in = sum;
         best_idx_in  = s1_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= '1;
         best_idx_ff  <= ENTRY_W'(1);
      end else begin
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
      end
   end

   assign nearest_index = best_idx_ff;
   assign best_distance = best_dist_ff;

endmodule

>>> hdl/nearest_palette_color.sv
// Nearest palette color search: a write beat stores one entry, with no response.
// A query rotates the palette ring of PALETTE_DEPTH cells once past one distance unit;
// then the drain and finish states follow; finish loads the response once any earlier
// one is taken. One query is in flight at a time; requests wait until the block is idle.
// Synchronous active-high reset zeroes every palette entry and empties the response stage.
module nearest_palette_color import npc_pkg::*; #(
   parameter int PALETTE_DEPTH = DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   npc_req_if.sink   req_chan,
   npc_rsp_if.source rsp_chan
);

   localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   npc_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   npc_color_type      query_ff, query_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rsp_index_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_load;

   logic               accept;
   logic               write_en;
   logic               query_start;
   logic               shift;
   npc_color_type      req_color;
   npc_color_type      cell_data [PALETTE_DEPTH];
   npc_tap_type        tap;
   logic [ENTRY_W-1:0] nearest_index;
   logic [DIST_W-1:0]  best_distance;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign write_en       = accept && (req_chan.op == OP_WRITE) &&
                           ((ENTRY_W+1)'(req_chan.entry) < (ENTRY_W+1)'(PALETTE_DEPTH));
   assign query_start    = accept && (req_chan.op == OP_QUERY);
   assign shift          = (state_ff == ST_SCAN);

   assign req_color.red   = req_chan.red;
   assign req_color.green = req_chan.green;
   assign req_color.blue  = req_chan.blue;

   // The ring turns one step per scan cycle and is back in place after a full turn.
   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      npc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (shift),
         .load      (write_en && (req_chan.entry[IDX_W-1:0] == IDX_W'(i))),
         .load_data (req_color),
         .next_data (cell_data[(i + 1) % PALETTE_DEPTH]),
         .data      (cell_data[i])
      );
   end

   // Entry zero passes the head first and is never a candidate.
   always_comb begin
      tap.seed  = query_start;
      tap.valid = shift && (cnt_ff != '0);
      tap.index = ENTRY_W'(cnt_ff);
   end

   npc_dist u_dist (
      .clock         (clock),
      .reset         (reset),
      .tap           (tap),
      .query         (query_ff),
      .entry         (cell_data[0]),
      .nearest_index (nearest_index),
      .best_distance (best_distance)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      query_in = query_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (query_start) begin
               query_in = req_color;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(PALETTE_DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= nearest_index;
         rsp_dist_ff  <= best_distance;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.nearest_index = rsp_index_ff;
   assign rsp_chan.best_distance = rsp_dist_ff;

endmodule

>>> hdl/npc_checker.sv
// Port-level assertions for the nearest palette color search, bound to the top level.
module npc_checker import npc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DIST_W-1:0]  rsp_best_distance
);

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   // A pending response beat is never withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped before it was taken");

   // A query occupies the search, so no further request beat is taken right after it.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_op == OP_QUERY) |=> !req_ready)
      else $error("request accepted while a query is being searched");

   // A response never shows up in the cycle after a request beat.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid))
      else $error("response appeared too soon after a request beat");

   // The distance reported never exceeds the largest possible RGB distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_distance <= DIST_W'(MAX_DISTANCE)))
      else $error("response distance out of range");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_op            (req_chan.op),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_best_distance (rsp_chan.best_distance)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the nearest palette color search: directed table, then random beats.
module testbench import npc_pkg::*; ();

   localparam int PALETTE_DEPTH = DEFAULT_DEPTH;
   localparam int DIRECTED_ROWS = 22;
   localparam int ROW_W = $clog2(DIRECTED_ROWS);
   localparam int RANDOM_ITEMS = 530;
   localparam int QUIET_TAIL = 60;
   localparam int REPORT_LIMIT = 10;
   localparam int unsigned DIST_SEED = 32'h7fff_ffff;

   typedef struct {
      logic [ENTRY_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } search_result_type;

   typedef struct {
      npc_op_type         op;
      logic [ENTRY_W-1:0] entry;
      npc_color_type      color;
      bit                 typed;
      search_result_type  want;
   } palette_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   npc_req_if req_chan ();
   npc_rsp_if rsp_chan ();

   nearest_palette_color #(.PALETTE_DEPTH(PALETTE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Queries carry junk in the entry field on purpose; the block must ignore it.
   palette_cmd_type directed_cmds [DIRECTED_ROWS] = '{
      '{OP_QUERY, 8'h00, 24'h000000, 1'b1, '{8'd1, 18'd0}},
      '{OP_QUERY, 8'hFF, 24'hFFFFFF, 1'b1, '{8'd1, 18'(MAX_DISTANCE)}},
      '{OP_WRITE, 8'h00, 24'hFFFFFF, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'hFFFFFF, 1'b1, '{8'd1, 18'(MAX_DISTANCE)}},
      '{OP_WRITE, 8'hFF, 24'hFFFFFF, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'hFFFFFF, 1'b1, '{8'd255, 18'd0}},
      '{OP_QUERY, 8'hFF, 24'h000000, 1'b1, '{8'd1, 18'd0}},
      '{OP_WRITE, 8'h01, 24'h0A141E, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'h0A141E, 1'b1, '{8'd1, 18'd0}},
      '{OP_WRITE, 8'h80, 24'h0A141E, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'h0A141E, 1'b1, '{8'd1, 18'd0}},
      '{OP_WRITE, 8'h01, 24'h000000, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'h0A141E, 1'b1, '{8'd128, 18'd0}},
      '{OP_WRITE, 8'hC8, 24'h00FF00, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'h00FF00, 1'b1, '{8'd200, 18'd0}},
      '{OP_WRITE, 8'h55, 24'h55AA55, 1'b0, '{8'd0, 18'd0}},
      '{OP_WRITE, 8'hAA, 24'hAA55AA, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'h56AB54, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h5A, 24'hAA55AB, 1'b0, '{8'd0, 18'd0}},
      '{OP_WRITE, 8'h02, 24'hFF0000, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'h00, 24'hF00000, 1'b0, '{8'd0, 18'd0}},
      '{OP_QUERY, 8'hFF, 24'h7F7F7F, 1'b0, '{8'd0, 18'd0}}
   };

   npc_color_type     palette_mirror [PALETTE_DEPTH];
   search_result_type pending_matches [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int sink_idle_pct = 0;
   int sink_stall_left = 0;
   bit quiet_tail = 1'b0;

   // Scan entries 1 and up; the strict compare keeps the lowest index on a tie.
   function automatic search_result_type find_nearest(npc_color_type probe);
      int unsigned best_dist;
      int unsigned cand_dist;
      int dr, dg, db;
      search_result_type found;
      best_dist = DIST_SEED;
      found.index = ENTRY_W'(1);
      for (int i = 1; i < PALETTE_DEPTH; i++) begin
         dr = int'(probe.red) - int'(palette_mirror[ENTRY_W'(i)].red);
         dg = int'(probe.green) - int'(palette_mirror[ENTRY_W'(i)].green);
         db = int'(probe.blue) - int'(palette_mirror[ENTRY_W'(i)].blue);
         cand_dist = dr * dr + dg * dg + db * db;
         if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            found.index = ENTRY_W'(i);
         end
      end
      if (best_dist == DIST_SEED) begin
         best_dist = 0;
      end
      found.distance = DIST_W'(best_dist);
      return found;
   endfunction

   function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) begin
         v = 0;
      end else if (v > 255) begin
         v = 255;
      end
      return COLOR_W'(v);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // Drive one request beat, with an optional idle burst in front, and record
   // what it should produce once the block takes it.
   task automatic push_request(input palette_cmd_type cmd);
      if (!quiet_tail && send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= cmd.op;
      req_chan.entry <= cmd.entry;
      req_chan.red   <= cmd.color.red;
      req_chan.green <= cmd.color.green;
      req_chan.blue  <= cmd.color.blue;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (cmd.op == OP_WRITE) begin
         if (cmd.entry < PALETTE_DEPTH) begin
            palette_mirror[cmd.entry] = cmd.color;
         end
      end else if (cmd.typed) begin
         pending_matches.push_back(cmd.want);
      end else begin
         pending_matches.push_back(find_nearest(cmd.color));
      end
   endtask

   initial begin
      palette_cmd_type cmd;
      npc_color_type   base;
      req_chan.valid = 1'b0;
      req_chan.op    = OP_WRITE;
      req_chan.entry = '0;
      req_chan.red   = '0;
      req_chan.green = '0;
      req_chan.blue  = '0;
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
         palette_mirror[ENTRY_W'(i)] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      sink_idle_pct = 10;
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         push_request(directed_cmds[ROW_W'(n)]);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  send_idle_pct = 0;
                  sink_idle_pct = 0;
               end
               1: begin
                  send_idle_pct = 15;
                  sink_idle_pct = 5;
               end
               default: begin
                  send_idle_pct = 40;
                  sink_idle_pct = 20;
               end
            endcase
         end
         if (n == RANDOM_ITEMS - QUIET_TAIL) begin
            quiet_tail = 1'b1;
         end
         cmd.typed = 1'b0;
         cmd.want = '{'0, '0};
         if ($urandom_range(0, 99) < 35) begin
            cmd.op = OP_QUERY;
            cmd.entry = ENTRY_W'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               cmd.color = 24'($urandom);
            end else begin
               // Aim close to a stored color so near misses and ties are exercised.
               base = palette_mirror[ENTRY_W'($urandom_range(0, PALETTE_DEPTH - 1))];
               cmd.color.red   = nudge(base.red);
               cmd.color.green = nudge(base.green);
               cmd.color.blue  = nudge(base.blue);
            end
         end else begin
            cmd.op = OP_WRITE;
            if ($urandom_range(0, 9) == 0) begin
               cmd.entry = ENTRY_W'($urandom_range(0, 3));
            end else begin
               cmd.entry = ENTRY_W'($urandom);
            end
            // Copying an existing entry's color builds duplicates, and so ties.
            if ($urandom_range(0, 2) == 0) begin
               cmd.color = palette_mirror[ENTRY_W'($urandom_range(0, PALETTE_DEPTH - 1))];
            end else begin
               cmd.color = 24'($urandom);
            end
         end
         push_request(cmd);
      end
      req_chan.valid <= 1'b0;

      while (pending_matches.size() != 0) @(posedge clock);
      repeat (PALETTE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_matches.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Response side: check each accepted beat, then choose the next ready level.
   initial begin
      search_result_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_matches.size() == 0) begin
               report_mismatch($sformatf("unexpected response index %0d distance %0d",
                                         rsp_chan.nearest_index, rsp_chan.best_distance));
            end else begin
               want = pending_matches.pop_front();
               if (rsp_chan.nearest_index !== want.index) begin
                  report_mismatch($sformatf("nearest_index expected %0d actual %0d",
                                            want.index, rsp_chan.nearest_index));
               end
               if (rsp_chan.best_distance !== want.distance) begin
                  report_mismatch($sformatf("best_distance expected %0d actual %0d",
                                            want.distance, rsp_chan.best_distance));
               end
            end
         end
         if (sink_stall_left > 0) begin
            sink_stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && sink_idle_pct > 0 &&
                      $urandom_range(1, 100) <= sink_idle_pct) begin
            sink_stall_left = $urandom_range(1, 9) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hdl/npc_pkg.sv
hdl/npc_channels_if.sv
hdl/npc_cell.sv
hdl/npc_dist.sv
hdl/nearest_palette_color.sv
hdl/npc_checker.sv
tb/testbench.sv
